/* sv/gvl_pkg.sv */
// Package for the vertex lighting block: unit widths, table word and light kind codes,
// controller states, datapath operations and the command/status structs.
// No dependencies.
package gvl_pkg;

   localparam int LIGHT_SLOTS_DEF = 8;

   localparam int SQ_W    = 34;
   localparam int SQ_R_W  = 17;
   localparam int MUL_A_W = 51;
   localparam int MUL_B_W = 36;
   localparam int MUL_P_W = 87;
   localparam int DIV_W   = 95;

   localparam logic [2:0] WORD_AMBIENT   = 3'd0;
   localparam logic [2:0] WORD_DIFFUSE   = 3'd1;
   localparam logic [2:0] WORD_DIRECTION = 3'd2;
   localparam logic [2:0] WORD_POSITION  = 3'd3;
   localparam logic [2:0] WORD_ATTEN     = 3'd4;

   localparam logic [1:0] KIND_AMBIENT  = 2'd0;
   localparam logic [1:0] KIND_INFINITE = 2'd1;
   localparam logic [1:0] KIND_POINT    = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_FETCH, S_CHECK, S_AMB, S_INF_DOT, S_INF_SUM, S_INF_CH,
      S_PT_VEC, S_PT_DOT, S_PT_CHK, S_SQD_GO, S_SQD_WAIT, S_SQN_GO, S_SQN_WAIT,
      S_ATT_GO, S_ATT_WAIT, S_ATT_SUM, S_DEN_GO, S_DEN_WAIT, S_NUM_GO, S_NUM_WAIT,
      S_DIV_INIT, S_DIV_STEP, S_ACC, S_NEXT, S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_CAPTURE, OP_FETCH, OP_AMB, OP_INF_DOT, OP_INF_SUM,
      OP_INF_CH, OP_PT_VEC, OP_PT_DOT, OP_SQD_GO, OP_SQD_WAIT, OP_SQN_GO,
      OP_SQN_WAIT, OP_ATT_GO, OP_ATT_SUM, OP_DEN_GO, OP_DEN_WAIT, OP_NUM_GO,
      OP_DIV_INIT, OP_DIV_STEP, OP_ACC
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic       light_en;
      logic [1:0] kind;
      logic       dot_pos;
      logic       unit_busy;
   } status_type;

endpackage

/* sv/gouraud_vertex_lighting.sv */
// Top level of the Gouraud vertex lighting block: controller plus datapath.
// Depends on gvl_pkg, gvl_ctrl and gvl_dp.
// A transaction is taken when start is high and busy is low. A table load (mode 0)
// leaves busy low. Shading a vertex (mode 1) scans the light table; the time spent on
// a point light is set by the shared bit-serial multiplier (five products) and the
// square root unit (two roots). The result is shown for exactly one cycle on rsp_valid
// and cannot be stalled, so the receiver must take it then.
module gouraud_vertex_lighting #(
   parameter  int LIGHT_SLOTS = gvl_pkg::LIGHT_SLOTS_DEF,
   localparam int IW = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [2:0]  req_light_index,
   input  logic [2:0]  req_light_word,
   input  logic [47:0] req_load_value,
   input  logic [15:0] req_base_color,
   input  logic [47:0] req_vertex_position,
   input  logic [47:0] req_vertex_normal,
   input  logic [47:0] req_face_normal,
   output logic        rsp_valid,
   output logic [15:0] rsp_lit_color,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);
   gvl_pkg::cmd_type    cmd;
   gvl_pkg::status_type status;
   logic [IW-1:0]       light_sel;

   gvl_ctrl #(.LIGHT_SLOTS(LIGHT_SLOTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .light_sel (light_sel)
   );

   gvl_dp #(.LIGHT_SLOTS(LIGHT_SLOTS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .light_sel           (light_sel),
      .req_light_index     (req_light_index),
      .req_light_word      (req_light_word),
      .req_load_value      (req_load_value),
      .req_base_color      (req_base_color),
      .req_vertex_position (req_vertex_position),
      .req_vertex_normal   (req_vertex_normal),
      .req_face_normal     (req_face_normal),
      .status              (status),
      .color_out           (rsp_lit_color)
   );

endmodule

/* sv/gvl_sqrt.sv */
// Bit-pair iterative integer square root, one result bit per cycle.
// Depends on gvl_pkg for its widths.
module gvl_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [gvl_pkg::SQ_W-1:0]    value,
   output logic                        busy,
   output logic [gvl_pkg::SQ_R_W-1:0]  root
);
   localparam int W  = gvl_pkg::SQ_W;
   localparam int CW = $clog2(W / 2 + 1);

   logic [W-1:0]  v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]    trial;

   always_comb begin
      trial  = {1'b0, r_ff} + {1'b0, bit_ff};
      v_in   = v_ff;
      r_in   = r_ff;
      bit_in = bit_ff;
      cnt_in = cnt_ff;
      if (go) begin
         v_in   = value;
         r_in   = '0;
         bit_in = W'(1) << (W - 2);
         cnt_in = CW'(W / 2);
      end else if (cnt_ff != '0) begin
         if ({1'b0, v_ff} >= trial) begin
            v_in = v_ff - trial[W-1:0];
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign busy = (cnt_ff != '0);
   assign root = r_ff[gvl_pkg::SQ_R_W-1:0];

endmodule

/* sv/gvl_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on gvl_pkg for its widths.
module gvl_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [gvl_pkg::MUL_A_W-1:0]  a,
   input  logic [gvl_pkg::MUL_B_W-1:0]  b,
   output logic                         busy,
   output logic [gvl_pkg::MUL_P_W-1:0]  prod
);
   localparam int PW = gvl_pkg::MUL_P_W;
   localparam int BW = gvl_pkg::MUL_B_W;
   localparam int CW = $clog2(BW + 1);

   logic [PW-1:0] a_ff, a_in, acc_ff, acc_in;
   logic [BW-1:0] b_ff, b_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (go) begin
         a_in   = PW'(a);
         b_in   = b;
         acc_in = '0;
         cnt_in = CW'(BW);
      end else if (cnt_ff != '0) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign busy = (cnt_ff != '0);
   assign prod = acc_ff;

endmodule

/* sv/gvl_dp.sv */
// Datapath: light table, per-light arithmetic, quotient steps and channel sums.
// Depends on gvl_pkg, gvl_sqrt and gvl_mul.
module gvl_dp #(
   parameter  int LIGHT_SLOTS = gvl_pkg::LIGHT_SLOTS_DEF,
   localparam int IW = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  gvl_pkg::cmd_type    cmd,
   input  logic [IW-1:0]       light_sel,
   input  logic [2:0]          req_light_index,
   input  logic [2:0]          req_light_word,
   input  logic [47:0]         req_load_value,
   input  logic [15:0]         req_base_color,
   input  logic [47:0]         req_vertex_position,
   input  logic [47:0]         req_vertex_normal,
   input  logic [47:0]         req_face_normal,
   output gvl_pkg::status_type status,
   output logic [15:0]         color_out
);
   localparam int IXW = (IW > 3) ? IW : 3;
   localparam int PW  = gvl_pkg::MUL_P_W;
   localparam int DW  = gvl_pkg::DIV_W;

   logic        tbl_en_ff   [LIGHT_SLOTS];
   logic [1:0]  tbl_kind_ff [LIGHT_SLOTS];
   logic [23:0] tbl_amb_ff  [LIGHT_SLOTS];
   logic [23:0] tbl_diff_ff [LIGHT_SLOTS];
   logic [47:0] tbl_dir_ff  [LIGHT_SLOTS];
   logic [47:0] tbl_pos_ff  [LIGHT_SLOTS];
   logic [47:0] tbl_att_ff  [LIGHT_SLOTS];

   logic        en_ff;
   logic [1:0]  kind_ff;
   logic [23:0] amb_ff, diff_ff;
   logic [47:0] dir_ff, pos_ff, att_ff;
   logic [7:0]  base_ff [3];
   logic [47:0] vp_ff, vn_ff, fn_ff;
   logic [15:0] db_ff [3];
   logic signed [31:0] prod_ff [3];
   logic signed [33:0] d_ff;
   logic signed [16:0] l_ff [3];
   logic signed [34:0] p_ff;
   logic [33:0] d2_ff;
   logic [31:0] n2_ff;
   logic [16:0] dist_ff, nlen_ff;
   logic [50:0] attv_ff;
   logic [33:0] nd_ff;
   logic [PW-1:0] den_ff;
   logic [DW-1:0] rem_ff, sh_ff;
   logic [7:0]  q_ff;
   logic        fixed_ff;
   logic [7:0]  sum_ff [3];

   logic signed [15:0] vp_l [3], vn_l [3], fn_l [3], dir_l [3], pos_l [3];
   logic [7:0]  amb_c [3], diff_c [3];
   logic signed [33:0] inf_sum;
   logic [IXW-1:0] wr_wide;
   logic [IW-1:0]  wr_idx;

   logic                        sq_go, sq_busy;
   logic [gvl_pkg::SQ_W-1:0]    sq_value;
   logic [gvl_pkg::SQ_R_W-1:0]  sq_root;
   logic                        mul_go, mul_busy;
   logic [gvl_pkg::MUL_A_W-1:0] mul_a;
   logic [gvl_pkg::MUL_B_W-1:0] mul_b;
   logic [PW-1:0]               mul_prod;

   logic [1:0]         ax;
   logic signed [32:0] pr_nl;
   logic signed [33:0] pr_ll;
   logic signed [31:0] pr_nn;
   logic [47:0]        inf_t;
   logic [15:0]        amb_p [3];
   logic [DW-1:0]      num_x, den8;

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         vp_l[a]   = vp_ff[16*a +: 16];
         vn_l[a]   = vn_ff[16*a +: 16];
         fn_l[a]   = fn_ff[16*a +: 16];
         dir_l[a]  = dir_ff[16*a +: 16];
         pos_l[a]  = pos_ff[16*a +: 16];
         amb_c[a]  = amb_ff[16-8*a +: 8];
         diff_c[a] = diff_ff[16-8*a +: 8];
         amb_p[a]  = amb_c[a] * base_ff[a];
      end
      inf_sum = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]);
      ax      = cmd.chan;
      pr_nl   = fn_l[ax] * l_ff[ax];
      pr_ll   = l_ff[ax] * l_ff[ax];
      pr_nn   = fn_l[ax] * fn_l[ax];
      inf_t   = db_ff[ax] * d_ff[31:0];
      num_x   = DW'(mul_prod);
      den8    = DW'({den_ff, 8'd0});
      wr_wide = IXW'(req_light_index);
      wr_idx  = wr_wide[IW-1:0];
   end

   always_comb begin
      sq_go    = (cmd.op == gvl_pkg::OP_SQD_GO) || (cmd.op == gvl_pkg::OP_SQN_GO);
      sq_value = (cmd.op == gvl_pkg::OP_SQN_GO) ? {2'b00, n2_ff} : d2_ff;
      mul_go   = (cmd.op == gvl_pkg::OP_ATT_GO) || (cmd.op == gvl_pkg::OP_DEN_GO) ||
                 (cmd.op == gvl_pkg::OP_NUM_GO);
      case (cmd.op)
         gvl_pkg::OP_ATT_GO: begin
            mul_a = gvl_pkg::MUL_A_W'(d2_ff);
            mul_b = gvl_pkg::MUL_B_W'(att_ff[47:32]);
         end
         gvl_pkg::OP_DEN_GO: begin
            mul_a = attv_ff;
            mul_b = gvl_pkg::MUL_B_W'(nd_ff);
         end
         default: begin
            mul_a = gvl_pkg::MUL_A_W'(p_ff[33:0]);
            mul_b = gvl_pkg::MUL_B_W'(db_ff[ax]);
         end
      endcase
   end

   gvl_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .go    (sq_go),
      .value (sq_value),
      .busy  (sq_busy),
      .root  (sq_root)
   );

   gvl_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (mul_busy),
      .prod  (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LIGHT_SLOTS; k++) begin
            tbl_en_ff[k]   <= 1'b0;
            tbl_kind_ff[k] <= '0;
            tbl_amb_ff[k]  <= '0;
            tbl_diff_ff[k] <= '0;
            tbl_dir_ff[k]  <= '0;
            tbl_pos_ff[k]  <= '0;
            tbl_att_ff[k]  <= '0;
         end
      end else if (cmd.op == gvl_pkg::OP_LOAD && int'(req_light_index) < LIGHT_SLOTS) begin
         case (req_light_word)
            gvl_pkg::WORD_AMBIENT: begin
               tbl_amb_ff[wr_idx]  <= req_load_value[23:0];
               tbl_kind_ff[wr_idx] <= req_load_value[25:24];
               tbl_en_ff[wr_idx]   <= req_load_value[26];
            end
            gvl_pkg::WORD_DIFFUSE:   tbl_diff_ff[wr_idx] <= req_load_value[23:0];
            gvl_pkg::WORD_DIRECTION: tbl_dir_ff[wr_idx]  <= req_load_value;
            gvl_pkg::WORD_POSITION:  tbl_pos_ff[wr_idx]  <= req_load_value;
            gvl_pkg::WORD_ATTEN:     tbl_att_ff[wr_idx]  <= req_load_value;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         gvl_pkg::OP_CAPTURE: begin
            base_ff[0] <= {req_base_color[15:11], 3'd0};
            base_ff[1] <= {req_base_color[10:5], 2'd0};
            base_ff[2] <= {req_base_color[4:0], 3'd0};
            vp_ff      <= req_vertex_position;
            vn_ff      <= req_vertex_normal;
            fn_ff      <= req_face_normal;
            for (int c = 0; c < 3; c++) sum_ff[c] <= '0;
         end
         gvl_pkg::OP_FETCH: begin
            en_ff   <= tbl_en_ff[light_sel];
            kind_ff <= tbl_kind_ff[light_sel];
            amb_ff  <= tbl_amb_ff[light_sel];
            diff_ff <= tbl_diff_ff[light_sel];
            dir_ff  <= tbl_dir_ff[light_sel];
            pos_ff  <= tbl_pos_ff[light_sel];
            att_ff  <= tbl_att_ff[light_sel];
         end
         gvl_pkg::OP_AMB: begin
            for (int c = 0; c < 3; c++) sum_ff[c] <= sat_add(sum_ff[c], amb_p[c][15:8]);
         end
         gvl_pkg::OP_INF_DOT: begin
            for (int a = 0; a < 3; a++) begin
               prod_ff[a] <= vn_l[a] * dir_l[a];
               db_ff[a]   <= diff_c[a] * base_ff[a];
            end
         end
         gvl_pkg::OP_INF_SUM: d_ff <= inf_sum;
         gvl_pkg::OP_INF_CH: begin
            sum_ff[ax] <= sat_add(sum_ff[ax],
                                  (inf_t[47:36] > 12'd255) ? 8'hFF : inf_t[43:36]);
         end
         gvl_pkg::OP_PT_VEC: begin
            for (int a = 0; a < 3; a++) begin
               l_ff[a]  <= {pos_l[a][15], pos_l[a]} - {vp_l[a][15], vp_l[a]};
               db_ff[a] <= diff_c[a] * base_ff[a];
            end
            p_ff  <= '0;
            d2_ff <= '0;
            n2_ff <= '0;
         end
         gvl_pkg::OP_PT_DOT: begin
            p_ff  <= p_ff + 35'(pr_nl);
            d2_ff <= d2_ff + 34'(pr_ll[31:0]);
            n2_ff <= n2_ff + 32'(pr_nn[30:0]);
         end
         gvl_pkg::OP_SQD_WAIT: dist_ff <= sq_root;
         gvl_pkg::OP_SQN_WAIT: nlen_ff <= sq_root;
         gvl_pkg::OP_ATT_SUM: begin
            attv_ff <= 51'(att_ff[15:0])
                       + 51'({17'd0, att_ff[31:16]} * {16'd0, dist_ff})
                       + mul_prod[50:0];
            nd_ff   <= nlen_ff * dist_ff;
         end
         gvl_pkg::OP_DEN_WAIT: den_ff <= mul_prod;
         gvl_pkg::OP_DIV_INIT: begin
            rem_ff <= num_x;
            sh_ff  <= DW'({den_ff, 7'd0});
            if (mul_prod == '0) begin
               q_ff     <= '0;
               fixed_ff <= 1'b1;
            end else if (den_ff == '0 || num_x >= den8) begin
               q_ff     <= 8'hFF;
               fixed_ff <= 1'b1;
            end else begin
               q_ff     <= '0;
               fixed_ff <= 1'b0;
            end
         end
         gvl_pkg::OP_DIV_STEP: begin
            if (!fixed_ff) begin
               if (rem_ff >= sh_ff) begin
                  rem_ff <= rem_ff - sh_ff;
                  q_ff   <= {q_ff[6:0], 1'b1};
               end else begin
                  q_ff   <= {q_ff[6:0], 1'b0};
               end
               sh_ff <= sh_ff >> 1;
            end
         end
         gvl_pkg::OP_ACC: sum_ff[ax] <= sat_add(sum_ff[ax], q_ff);
         default: ;
      endcase
   end

   always_comb begin
      status.light_en  = en_ff;
      status.kind      = kind_ff;
      status.dot_pos   = (cmd.op == gvl_pkg::OP_INF_SUM) ? (inf_sum > 34'sd0)
                                                         : (p_ff > 35'sd0);
      status.unit_busy = sq_busy | mul_busy;
   end

   assign color_out = {sum_ff[0][7:3], sum_ff[1][7:2], sum_ff[2][7:3]};

endmodule

/* sv/gvl_ctrl.sv */
// Controller: sequencing state machine, light, channel and step counters, light_count register.
// Depends on gvl_pkg.
module gvl_ctrl #(
   parameter  int LIGHT_SLOTS = gvl_pkg::LIGHT_SLOTS_DEF,
   localparam int IW = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_mode,
   input  logic                csr_we,
   input  logic [3:0]          csr_wdata,
   input  gvl_pkg::status_type status,
   output logic                busy,
   output logic                rsp_valid,
   output gvl_pkg::cmd_type    cmd,
   output logic [IW-1:0]       light_sel
);
   localparam int CW = $clog2(LIGHT_SLOTS + 1);
   localparam int SW = (CW > 4) ? CW : 4;

   gvl_pkg::state_type state_ff, state_in;
   logic [IW-1:0] light_ff, light_in;
   logic [1:0]    chan_ff, chan_in;
   logic [2:0]    step_ff, step_in;
   logic [3:0]    light_count_ff;
   logic [SW-1:0] scan;
   logic          last;

   always_comb begin
      scan = (SW'(light_count_ff) > SW'(LIGHT_SLOTS)) ? SW'(LIGHT_SLOTS)
                                                       : SW'(light_count_ff);
      last = (SW'(light_ff) + SW'(1)) == scan;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gvl_pkg::S_IDLE: begin
            if (start && req_mode) begin
               state_in = (scan == '0) ? gvl_pkg::S_DONE : gvl_pkg::S_FETCH;
            end
         end
         gvl_pkg::S_FETCH: state_in = gvl_pkg::S_CHECK;
         gvl_pkg::S_CHECK: begin
            if (!status.light_en) begin
               state_in = gvl_pkg::S_NEXT;
            end else begin
               case (status.kind)
                  gvl_pkg::KIND_AMBIENT:  state_in = gvl_pkg::S_AMB;
                  gvl_pkg::KIND_INFINITE: state_in = gvl_pkg::S_INF_DOT;
                  gvl_pkg::KIND_POINT:    state_in = gvl_pkg::S_PT_VEC;
                  default:                state_in = gvl_pkg::S_NEXT;
               endcase
            end
         end
         gvl_pkg::S_AMB:     state_in = gvl_pkg::S_NEXT;
         gvl_pkg::S_INF_DOT: state_in = gvl_pkg::S_INF_SUM;
         gvl_pkg::S_INF_SUM: state_in = status.dot_pos ? gvl_pkg::S_INF_CH : gvl_pkg::S_NEXT;
         gvl_pkg::S_INF_CH:  if (chan_ff == 2'd2) state_in = gvl_pkg::S_NEXT;
         gvl_pkg::S_PT_VEC:  state_in = gvl_pkg::S_PT_DOT;
         gvl_pkg::S_PT_DOT:  if (chan_ff == 2'd2) state_in = gvl_pkg::S_PT_CHK;
         gvl_pkg::S_PT_CHK:  state_in = status.dot_pos ? gvl_pkg::S_SQD_GO : gvl_pkg::S_NEXT;
         gvl_pkg::S_SQD_GO:  state_in = gvl_pkg::S_SQD_WAIT;
         gvl_pkg::S_SQD_WAIT: if (!status.unit_busy) state_in = gvl_pkg::S_SQN_GO;
         gvl_pkg::S_SQN_GO:  state_in = gvl_pkg::S_SQN_WAIT;
         gvl_pkg::S_SQN_WAIT: if (!status.unit_busy) state_in = gvl_pkg::S_ATT_GO;
         gvl_pkg::S_ATT_GO:  state_in = gvl_pkg::S_ATT_WAIT;
         gvl_pkg::S_ATT_WAIT: if (!status.unit_busy) state_in = gvl_pkg::S_ATT_SUM;
         gvl_pkg::S_ATT_SUM: state_in = gvl_pkg::S_DEN_GO;
         gvl_pkg::S_DEN_GO:  state_in = gvl_pkg::S_DEN_WAIT;
         gvl_pkg::S_DEN_WAIT: if (!status.unit_busy) state_in = gvl_pkg::S_NUM_GO;
         gvl_pkg::S_NUM_GO:  state_in = gvl_pkg::S_NUM_WAIT;
         gvl_pkg::S_NUM_WAIT: if (!status.unit_busy) state_in = gvl_pkg::S_DIV_INIT;
         gvl_pkg::S_DIV_INIT: state_in = gvl_pkg::S_DIV_STEP;
         gvl_pkg::S_DIV_STEP: if (step_ff == 3'd7) state_in = gvl_pkg::S_ACC;
         gvl_pkg::S_ACC: state_in = (chan_ff == 2'd2) ? gvl_pkg::S_NEXT : gvl_pkg::S_NUM_GO;
         gvl_pkg::S_NEXT: state_in = last ? gvl_pkg::S_DONE : gvl_pkg::S_FETCH;
         gvl_pkg::S_DONE: state_in = gvl_pkg::S_IDLE;
         default: state_in = gvl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      light_in = light_ff;
      chan_in  = chan_ff;
      step_in  = step_ff;
      case (state_ff)
         gvl_pkg::S_IDLE:  light_in = '0;
         gvl_pkg::S_FETCH: chan_in = '0;
         gvl_pkg::S_INF_CH, gvl_pkg::S_PT_DOT, gvl_pkg::S_ACC: begin
            chan_in = (chan_ff == 2'd2) ? 2'd0 : chan_ff + 2'd1;
         end
         gvl_pkg::S_DIV_INIT: step_in = '0;
         gvl_pkg::S_DIV_STEP: step_in = step_ff + 3'd1;
         gvl_pkg::S_NEXT: if (!last) light_in = light_ff + IW'(1);
         default: ;
      endcase
   end

   always_comb begin
      cmd.chan = chan_ff;
      case (state_ff)
         gvl_pkg::S_IDLE: begin
            if (start) begin
               cmd.op = req_mode ? gvl_pkg::OP_CAPTURE : gvl_pkg::OP_LOAD;
            end else begin
               cmd.op = gvl_pkg::OP_NONE;
            end
         end
         gvl_pkg::S_FETCH:    cmd.op = gvl_pkg::OP_FETCH;
         gvl_pkg::S_AMB:      cmd.op = gvl_pkg::OP_AMB;
         gvl_pkg::S_INF_DOT:  cmd.op = gvl_pkg::OP_INF_DOT;
         gvl_pkg::S_INF_SUM:  cmd.op = gvl_pkg::OP_INF_SUM;
         gvl_pkg::S_INF_CH:   cmd.op = gvl_pkg::OP_INF_CH;
         gvl_pkg::S_PT_VEC:   cmd.op = gvl_pkg::OP_PT_VEC;
         gvl_pkg::S_PT_DOT:   cmd.op = gvl_pkg::OP_PT_DOT;
         gvl_pkg::S_SQD_GO:   cmd.op = gvl_pkg::OP_SQD_GO;
         gvl_pkg::S_SQD_WAIT: cmd.op = gvl_pkg::OP_SQD_WAIT;
         gvl_pkg::S_SQN_GO:   cmd.op = gvl_pkg::OP_SQN_GO;
         gvl_pkg::S_SQN_WAIT: cmd.op = gvl_pkg::OP_SQN_WAIT;
         gvl_pkg::S_ATT_GO:   cmd.op = gvl_pkg::OP_ATT_GO;
         gvl_pkg::S_ATT_SUM:  cmd.op = gvl_pkg::OP_ATT_SUM;
         gvl_pkg::S_DEN_GO:   cmd.op = gvl_pkg::OP_DEN_GO;
         gvl_pkg::S_DEN_WAIT: cmd.op = gvl_pkg::OP_DEN_WAIT;
         gvl_pkg::S_NUM_GO:   cmd.op = gvl_pkg::OP_NUM_GO;
         gvl_pkg::S_DIV_INIT: cmd.op = gvl_pkg::OP_DIV_INIT;
         gvl_pkg::S_DIV_STEP: cmd.op = gvl_pkg::OP_DIV_STEP;
         gvl_pkg::S_ACC:      cmd.op = gvl_pkg::OP_ACC;
         default:             cmd.op = gvl_pkg::OP_NONE;
      endcase
      busy      = (state_ff != gvl_pkg::S_IDLE);
      rsp_valid = (state_ff == gvl_pkg::S_DONE);
      light_sel = light_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gvl_pkg::S_IDLE;
         light_ff       <= '0;
         chan_ff        <= '0;
         step_ff        <= '0;
         light_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         light_ff <= light_in;
         chan_ff  <= chan_in;
         step_ff  <= step_in;
         if (csr_we) begin
            light_count_ff <= csr_wdata;
         end
      end
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result strobe held for more than one cycle.");

   a_shade_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gvl_pkg::S_IDLE && start && req_mode) |=> busy)
      else $error("Shading transaction accepted without going busy.");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gvl_pkg::S_DIV_STEP && step_ff == 3'd7) |=> (state_ff == gvl_pkg::S_ACC))
      else $error("Quotient steps did not end after eight cycles.");

   a_sqrt_started: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gvl_pkg::S_SQD_GO) |=> status.unit_busy)
      else $error("Square root unit did not start.");

endmodule

/* tb/gouraud_vertex_lighting_tb.sv */
// Self-checking testbench for gouraud_vertex_lighting: loads light tables, shades vertices
// and compares every lit color with a cycle-free model of the lighting sums.
// Depends on gvl_pkg and gouraud_vertex_lighting.
module gouraud_vertex_lighting_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 8;
   localparam int RANDOM_CMDS = 1550;
   localparam longint CYCLE_LIMIT = 20_000_000;
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_SHADE = 1'b1;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic        mode;
      logic [2:0]  index;
      logic [2:0]  word;
      logic [47:0] load;
      logic [15:0] base;
      logic [47:0] vpos;
      logic [47:0] vnorm;
      logic [47:0] fnorm;
   } light_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = 1'b0;
   logic [2:0]  req_light_index = '0;
   logic [2:0]  req_light_word = '0;
   logic [47:0] req_load_value = '0;
   logic [15:0] req_base_color = '0;
   logic [47:0] req_vertex_position = '0;
   logic [47:0] req_vertex_normal = '0;
   logic [47:0] req_face_normal = '0;
   logic        rsp_valid;
   logic [15:0] rsp_lit_color;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_wdata = '0;

   logic        tbl_enabled [TABLE_DEPTH];
   logic [1:0]  tbl_kind [TABLE_DEPTH];
   logic [23:0] tbl_ambient [TABLE_DEPTH];
   logic [23:0] tbl_diffuse [TABLE_DEPTH];
   logic [47:0] tbl_direction [TABLE_DEPTH];
   logic [47:0] tbl_position [TABLE_DEPTH];
   logic [47:0] tbl_atten [TABLE_DEPTH];
   logic [3:0]  scan_count = '0;

   logic [15:0] expected_colors[$];
   int          error_count = 0;
   longint      cycle_count = 0;
   bit          pacing_on = 1'b1;

   always #1 clock = ~clock;

   gouraud_vertex_lighting dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_light_index(req_light_index),
      .req_light_word(req_light_word), .req_load_value(req_load_value),
      .req_base_color(req_base_color), .req_vertex_position(req_vertex_position),
      .req_vertex_normal(req_vertex_normal), .req_face_normal(req_face_normal),
      .rsp_valid(rsp_valid), .rsp_lit_color(rsp_lit_color),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   function automatic longint lane(logic [47:0] w, int a);
      return longint'($signed(w[16*a +: 16]));
   endfunction

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] predict_color(logic [15:0] bc, logic [47:0] vp,
                                                 logic [47:0] vn, logic [47:0] fn);
      longint unsigned base [3];
      longint unsigned total [3];
      longint d, p, nf;
      longint lv [3];
      longint unsigned d2, n2, light_range, nlen, att, num, t, ch;
      int scan;
      base[0] = {bc[15:11], 3'b000};
      base[1] = {bc[10:5], 2'b00};
      base[2] = {bc[4:0], 3'b000};
      total = '{0, 0, 0};
      scan = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : scan_count;
      for (int k = 0; k < scan; k++) begin
         if (!tbl_enabled[k]) continue;
         if (tbl_kind[k] == gvl_pkg::KIND_AMBIENT) begin
            for (int c = 0; c < 3; c++) begin
               ch = tbl_ambient[k][23-8*c -: 8];
               total[c] += (ch * base[c]) >> 8;
            end
         end else if (tbl_kind[k] == gvl_pkg::KIND_INFINITE) begin
            d = 0;
            for (int a = 0; a < 3; a++) d += lane(vn, a) * lane(tbl_direction[k], a);
            if (d > 0) begin
               for (int c = 0; c < 3; c++) begin
                  ch = tbl_diffuse[k][23-8*c -: 8];
                  t = (ch * base[c] * longint'(d)) >> 36;
                  total[c] += (t > 255) ? 255 : t;
               end
            end
         end else if (tbl_kind[k] == gvl_pkg::KIND_POINT) begin
            p = 0;
            d2 = 0;
            n2 = 0;
            for (int a = 0; a < 3; a++) begin
               nf = lane(fn, a);
               lv[a] = lane(tbl_position[k], a) - lane(vp, a);
               p += nf * lv[a];
               d2 += lv[a] * lv[a];
               n2 += nf * nf;
            end
            if (p > 0) begin
               light_range = isqrt(d2);
               nlen = isqrt(n2);
               att = longint'(tbl_atten[k][15:0])
                     + longint'(tbl_atten[k][31:16]) * light_range
                     + longint'(tbl_atten[k][47:32]) * d2;
               for (int c = 0; c < 3; c++) begin
                  ch = tbl_diffuse[k][23-8*c -: 8];
                  num = ch * base[c] * longint'(p);
                  if (num == 0) t = 0;
                  else if (att == 0 || nlen == 0 || light_range == 0) t = 255;
                  else t = ((num / nlen) / light_range) / att;
                  total[c] += (t > 255) ? 255 : t;
               end
            end
         end
      end
      for (int c = 0; c < 3; c++) if (total[c] > 255) total[c] = 255;
      return {total[0][7:3], total[1][7:2], total[2][7:3]};
   endfunction

   function automatic void apply_command(light_cmd_type c);
      if (c.mode == MODE_SHADE) begin
         expected_colors.push_back(predict_color(c.base, c.vpos, c.vnorm, c.fnorm));
      end else begin
         case (c.word)
            gvl_pkg::WORD_AMBIENT: begin
               tbl_ambient[c.index] = c.load[23:0];
               tbl_kind[c.index] = c.load[25:24];
               tbl_enabled[c.index] = c.load[26];
            end
            gvl_pkg::WORD_DIFFUSE:   tbl_diffuse[c.index] = c.load[23:0];
            gvl_pkg::WORD_DIRECTION: tbl_direction[c.index] = c.load;
            gvl_pkg::WORD_POSITION:  tbl_position[c.index] = c.load;
            gvl_pkg::WORD_ATTEN:     tbl_atten[c.index] = c.load;
            default: ;
         endcase
      end
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (!pacing_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [47:0] rand48();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [15:0] rand_q14();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic logic [15:0] rand_coord();
      if ($urandom_range(0, 9) == 0) return 16'($urandom());
      return 16'($signed($urandom_range(0, 4000)) - 2000);
   endfunction

   function automatic light_cmd_type load_cmd(int idx, logic [2:0] word, logic [47:0] value);
      light_cmd_type c;
      c = '{MODE_LOAD, 3'(idx), word, value, 16'($urandom()), rand48(), rand48(), rand48()};
      return c;
   endfunction

   function automatic light_cmd_type shade_cmd(logic [15:0] bc, logic [47:0] vp,
                                               logic [47:0] vn, logic [47:0] fn);
      light_cmd_type c;
      c = '{MODE_SHADE, 3'($urandom()), 3'($urandom()), rand48(), bc, vp, vn, fn};
      return c;
   endfunction

   task automatic send_command(light_cmd_type c);
      int gap;
      start <= 1'b1;
      req_mode <= c.mode;
      req_light_index <= c.index;
      req_light_word <= c.word;
      req_load_value <= c.load;
      req_base_color <= c.base;
      req_vertex_position <= c.vpos;
      req_vertex_normal <= c.vnorm;
      req_face_normal <= c.fnorm;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_command(c);
      gap = gap_length();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_light_count(logic [3:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      scan_count = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_light(int idx, bit en, logic [1:0] kind, logic [23:0] amb,
                             logic [23:0] dif, logic [47:0] dir, logic [47:0] pos,
                             logic [47:0] att);
      send_command(load_cmd(idx, gvl_pkg::WORD_AMBIENT, {21'($urandom()), en, kind, amb}));
      send_command(load_cmd(idx, gvl_pkg::WORD_DIFFUSE, {24'($urandom()), dif}));
      send_command(load_cmd(idx, gvl_pkg::WORD_DIRECTION, dir));
      send_command(load_cmd(idx, gvl_pkg::WORD_POSITION, pos));
      send_command(load_cmd(idx, gvl_pkg::WORD_ATTEN, att));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_colors.size() == 0) begin
            $error("rsp_lit_color: unexpected transaction, actual %h", rsp_lit_color);
            error_count++;
         end else begin
            if (rsp_lit_color !== expected_colors[0]) begin
               $error("rsp_lit_color: expected %h actual %h", expected_colors[0],
                      rsp_lit_color);
               error_count++;
            end
            void'(expected_colors.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic test_empty_scan();
      send_command(shade_cmd(16'hFFFF, rand48(), rand48(), rand48()));
      write_light_count(4'd15);
      send_command(shade_cmd(16'hFFFF, 48'h0, 48'h0, 48'h0));
   endtask

   task automatic test_ambient();
      load_light(0, 1'b1, gvl_pkg::KIND_AMBIENT, 24'hFFFFFF, 24'h0, 48'h0, 48'h0, 48'h0);
      send_command(shade_cmd(16'hFFFF, 48'h0, 48'h0, 48'h0));
      send_command(shade_cmd(16'h0000, 48'h0, 48'h0, 48'h0));
   endtask

   task automatic test_infinite();
      load_light(1, 1'b1, gvl_pkg::KIND_INFINITE, 24'h0, 24'hFFFFFF, {16'd16384, 32'h0},
                 48'h0, 48'h0);
      send_command(shade_cmd(16'hFFFF, 48'h0, {16'd16384, 32'h0}, 48'h0));
      send_command(shade_cmd(16'h8410, 48'h0, {16'hC000, 32'h0}, 48'h0));
   endtask

   task automatic test_point();
      load_light(2, 1'b1, gvl_pkg::KIND_POINT, 24'h0, 24'h80FF40, 48'h0, {16'd100, 32'h0},
                 {16'h0, 16'h0, 16'h0100});
      send_command(shade_cmd(16'hFFFF, 48'h0, 48'h0, {16'd16384, 32'h0}));
      send_command(shade_cmd(16'hFFFF, {16'd100, 32'h0}, 48'h0, {16'd16384, 32'h0}));
      send_command(load_cmd(2, gvl_pkg::WORD_ATTEN, 48'h0));
      send_command(shade_cmd(16'h07E0, 48'h0, 48'h0, {16'd16384, 32'h0}));
      send_command(shade_cmd(16'h7FFF, {16'h8000, 16'h7FFF, 16'h8000}, 48'h0,
                             {16'h7FFF, 16'h8000, 16'h7FFF}));
   endtask

   task automatic test_unused_kind_and_words();
      load_light(3, 1'b1, KIND_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF,
                 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_command(load_cmd(0, 3'd5, 48'hFFFF_FFFF_FFFF));
      send_command(load_cmd(1, 3'd6, 48'h0));
      send_command(load_cmd(7, 3'd7, 48'hFFFF_FFFF_FFFF));
      write_light_count(4'd8);
      send_command(shade_cmd(16'hFFFF, 48'h0, {16'd16384, 32'h0}, {16'd16384, 32'h0}));
   endtask

   task automatic test_random_scenes();
      int sent;
      int nlights;
      logic [1:0] kind;
      sent = 0;
      while (sent < RANDOM_CMDS) begin
         pacing_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: write_light_count(4'd0);
               1: write_light_count(4'd8);
               2: write_light_count(4'd15);
               default: write_light_count(4'($urandom_range(1, 9)));
            endcase
         end
         nlights = $urandom_range(1, 4);
         for (int n = 0; n < nlights; n++) begin
            kind = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
            load_light($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 7) != 0, kind,
                       24'($urandom()), 24'($urandom()),
                       {rand_q14(), rand_q14(), rand_q14()},
                       {rand_coord(), rand_coord(), rand_coord()},
                       ($urandom_range(0, 7) == 0) ? rand48() :
                       {16'($urandom_range(0, 3)), 16'($urandom_range(0, 64)),
                        16'($urandom_range(0, 512))});
            sent += 5;
         end
         if ($urandom_range(0, 3) == 0) begin
            send_command(load_cmd($urandom_range(0, TABLE_DEPTH - 1),
                                  3'($urandom_range(0, 7)), rand48()));
            sent++;
         end
         for (int v = $urandom_range(2, 8); v > 0; v--) begin
            if ($urandom_range(0, 9) == 0)
               send_command(shade_cmd(16'($urandom()), rand48(), rand48(), rand48()));
            else
               send_command(shade_cmd(16'($urandom()),
                                      {rand_coord(), rand_coord(), rand_coord()},
                                      {rand_q14(), rand_q14(), rand_q14()},
                                      {rand_q14(), rand_q14(), rand_q14()}));
            sent++;
         end
      end
   endtask

   initial begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         tbl_enabled[k] = 1'b0;
         tbl_kind[k] = '0;
         tbl_ambient[k] = '0;
         tbl_diffuse[k] = '0;
         tbl_direction[k] = '0;
         tbl_position[k] = '0;
         tbl_atten[k] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_scan();
      test_ambient();
      test_infinite();
      test_point();
      test_unused_kind_and_words();
      test_random_scenes();
      wait_drained();
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
